// File: rtl/core/abr_pkg.sv
// Shared constants and types for the alternating-bit receiver.
`default_nettype none

package abr_pkg;

   // Datagram layout: a 12-byte header of three 32-bit fields, then the data.
   localparam int MAX_DATA    = 10;
   localparam int HDR_BYTES   = 12;
   localparam int FRAME_BYTES = HDR_BYTES + MAX_DATA;

   // Byte counter, data index and data length widths.
   localparam int POS_W = $clog2(FRAME_BYTES + 1);
   localparam int IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam int LEN_W = $clog2(MAX_DATA + 1);

   // Depth of the packet queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Kind of a result item.
   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_ACK  = 1'b1
   } result_kind_type;

   // One classified datagram, as handed from the front to the back.
   typedef struct packed {
      logic                         good;
      logic                         done;
      logic                         ack_seq;
      logic [LEN_W-1:0]             len;
      logic [MAX_DATA-1:0][7:0]     payload;
   } pkt_desc_type;

   // Fill status of the packet queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// File: rtl/core/alternating_bit_receiver.sv
// Top level of the alternating-bit receiver: front, packet queue and back.
//
// Usage: the request channel carries one datagram byte per request, the
// byte on tdata and the end-of-datagram mark on tlast. A datagram is a
// 12-byte little-endian header (sequence, length, checksum) and its data.
// The response channel gives, for a good datagram with the expected
// sequence, its data bytes (tuser low) and then an ACK (tuser high, tlast
// high); any other datagram gives a single ACK of the previous sequence.
// Throughput: one request per cycle while the queue is not full and one
// response per cycle while rsp_tready is high. The front classifies a
// datagram on the cycle of its last byte; it then goes through the packet
// queue and the response register, and an ACK follows L data responses.
// A two-entry packet queue, each entry holding a whole datagram's data,
// decouples the sides: requests stall only when both entries wait for
// the back, so a stalled response channel holds at most two datagrams
// before req_tready falls. Reset clears the expected sequence bit, the
// frame counters, the queue and the response valid flag; no clearing pass.
`default_nettype none

module alternating_bit_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tlast,   // end_of_datagram
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] data_byte, [8] ack_seq, [9] ack_checksum,
                                         // [10] packet_good, [11] transfer_done, [15:12] zero
   output logic             rsp_tuser,   // result_kind
   output logic             rsp_tlast    // last
);

   abr_pkg::queue_status_type q_status;
   abr_pkg::pkt_desc_type     push_desc;
   abr_pkg::pkt_desc_type     head;
   logic                      push;
   logic                      pop;

   abr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .desc       (push_desc)
   );

   abr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   abr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The queue is never written while full nor read while empty.
   assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full) && !(pop && q_status.empty))
      else $error("packet queue overflow or underflow");

   // Only an ACK closes a datagram's responses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser))
      else $error("last flag does not match result kind");

   // A finished transfer is only reported on the ACK of a good datagram.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[11]) |-> (rsp_tuser && rsp_tdata[10]))
      else $error("transfer done on a non-good or data result");

   // A response waiting to be taken holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled response changed");

endmodule

`default_nettype wire

// File: rtl/core/abr_front.sv
// Front part: parses datagram bytes, buffers the data and classifies each datagram.
`default_nettype none

module abr_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,   // [7:0] rx_byte
   input  wire logic                     req_tlast,   // end_of_datagram
   input  wire abr_pkg::queue_status_type q_status,
   output logic                          push,
   output abr_pkg::pkt_desc_type         desc
);

   logic [abr_pkg::POS_W-1:0]             pos_ff, pos_in;
   logic [31:0]                           seq_ff, seq_in;
   logic [31:0]                           len_ff, len_in;
   logic [31:0]                           chk_ff, chk_in;
   logic [7:0]                            xor_ff, xor_in;
   logic                                  exp_seq_ff, exp_seq_in;
   logic [abr_pkg::MAX_DATA-1:0][7:0]     store_ff, store_in;

   logic                                  accept;
   logic [1:0]                            lane;
   logic [abr_pkg::POS_W-1:0]             pos_off;
   logic [abr_pkg::IDX_W-1:0]             idx;
   logic                                  ok;
   logic                                  done;

   // Bytes are taken whenever the queue has room for a finished datagram.
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign lane       = pos_ff[1:0];
   assign pos_off    = pos_ff - abr_pkg::POS_W'(abr_pkg::HDR_BYTES);
   assign idx        = pos_off[abr_pkg::IDX_W-1:0];

   // Field capture, data buffering, checksum and classification.
   always_comb begin
      pos_in     = pos_ff;
      seq_in     = seq_ff;
      len_in     = len_ff;
      chk_in     = chk_ff;
      xor_in     = xor_ff;
      store_in   = store_ff;
      exp_seq_in = exp_seq_ff;

      if (pos_ff < abr_pkg::POS_W'(abr_pkg::HDR_BYTES)) begin
         if (pos_ff < abr_pkg::POS_W'(4)) begin
            seq_in[{lane, 3'b000} +: 8] = req_tdata;
            xor_in = xor_ff ^ req_tdata;
         end else if (pos_ff < abr_pkg::POS_W'(8)) begin
            len_in[{lane, 3'b000} +: 8] = req_tdata;
            xor_in = xor_ff ^ req_tdata;
         end else begin
            chk_in[{lane, 3'b000} +: 8] = req_tdata;
         end
      end else if (pos_ff < abr_pkg::POS_W'(abr_pkg::FRAME_BYTES)) begin
         store_in[idx] = req_tdata;
         if (32'(pos_off) < len_ff) begin
            xor_in = xor_ff ^ req_tdata;
         end
      end
      if (pos_ff < abr_pkg::POS_W'(abr_pkg::FRAME_BYTES)) begin
         pos_in = pos_ff + abr_pkg::POS_W'(1);
      end

      // The datagram is judged on the fields as they stand after this byte.
      ok = (pos_in >= abr_pkg::POS_W'(abr_pkg::HDR_BYTES))
         && (len_in <= 32'(abr_pkg::MAX_DATA))
         && (32'(pos_in) >= 32'(abr_pkg::HDR_BYTES) + len_in)
         && (chk_in == {{24{xor_in[7]}}, xor_in})
         && (seq_in == {31'b0, exp_seq_ff});
      done = ok && (len_in == 32'd0);

      push = accept && req_tlast;
      desc.good    = ok;
      desc.done    = done;
      desc.ack_seq = ok ? exp_seq_ff : !exp_seq_ff;
      desc.len     = len_in[abr_pkg::LEN_W-1:0];
      desc.payload = store_in;

      // Closing a datagram clears the frame state and, if it is good, moves the expected bit.
      if (push) begin
         if (ok) begin
            exp_seq_in = done ? 1'b0 : !exp_seq_ff;
         end
         pos_in = '0;
         seq_in = '0;
         len_in = '0;
         chk_in = '0;
         xor_in = '0;
      end
   end

   // Control and frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         seq_ff     <= '0;
         len_ff     <= '0;
         chk_ff     <= '0;
         xor_ff     <= '0;
         exp_seq_ff <= 1'b0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         seq_ff     <= seq_in;
         len_ff     <= len_in;
         chk_ff     <= chk_in;
         xor_ff     <= xor_in;
         exp_seq_ff <= exp_seq_in;
      end
   end

   // Data buffer; only bytes written in the current datagram are ever used.
   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= store_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/abr_queue.sv
// Short queue of classified datagrams between the front and back parts.
`default_nettype none

module abr_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire abr_pkg::pkt_desc_type push_desc,
   input  wire logic                  pop,
   output abr_pkg::pkt_desc_type      head,
   output abr_pkg::queue_status_type  status
);

   abr_pkg::pkt_desc_type             entry_ff [abr_pkg::QUEUE_DEPTH];
   logic [abr_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [abr_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [abr_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign status.full  = (count_ff == abr_pkg::QCNT_W'(abr_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == abr_pkg::QPTR_W'(abr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + abr_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == abr_pkg::QPTR_W'(abr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + abr_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + abr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - abr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/abr_back.sv
// Back part: turns each queued datagram into data byte results and an ACK.
`default_nettype none

module abr_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire abr_pkg::pkt_desc_type    head,
   input  wire abr_pkg::queue_status_type q_status,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [15:0]                   rsp_tdata,  // [7:0] data_byte, [8] ack_seq,
                                                     // [9] ack_checksum, [10] packet_good,
                                                     // [11] transfer_done, [15:12] zero
   output logic                          rsp_tuser,  // result_kind
   output logic                          rsp_tlast   // last
);

   logic [abr_pkg::LEN_W-1:0] cnt_ff, cnt_in;
   logic                      valid_ff, valid_in;
   abr_pkg::result_kind_type  kind_ff, kind_in;
   logic [7:0]                data_ff, data_in;
   logic                      seq_ff, seq_in;
   logic                      good_ff, good_in;
   logic                      done_ff, done_in;
   logic                      last_ff, last_in;

   logic                      load;
   logic                      is_data;

   // A new result enters the output register when it is empty or being taken.
   assign load    = !q_status.empty && (!valid_ff || rsp_tready);
   assign is_data = head.good && (cnt_ff < head.len);
   assign pop     = load && !is_data;

   always_comb begin
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      data_in  = data_ff;
      seq_in   = seq_ff;
      good_in  = good_ff;
      done_in  = done_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         good_in  = head.good;
         if (is_data) begin
            kind_in = abr_pkg::KIND_DATA;
            data_in = head.payload[cnt_ff[abr_pkg::IDX_W-1:0]];
            seq_in  = 1'b0;
            done_in = 1'b0;
            last_in = 1'b0;
            cnt_in  = cnt_ff + abr_pkg::LEN_W'(1);
         end else begin
            kind_in = abr_pkg::KIND_ACK;
            data_in = 8'd0;
            seq_in  = head.ack_seq;
            done_in = head.done;
            last_in = 1'b1;
            cnt_in  = '0;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      data_ff <= data_in;
      seq_ff  <= seq_in;
      good_ff <= good_in;
      done_ff <= done_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, done_ff, good_ff, seq_ff, seq_ff, data_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// File: dv/tb_alternating_bit_receiver.sv
// Self-checking testbench for the alternating-bit receiver: datagram stimulus and response checks.
`timescale 1ns / 1ps

module tb_alternating_bit_receiver;

   localparam int HALF_PERIOD  = 4;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 200;
   localparam int REPORT_LIMIT = 10;

   // One response as it appears on the response channel.
   typedef struct packed {
      abr_pkg::result_kind_type kind;
      logic [7:0]               data_byte;
      logic                     ack_seq;
      logic                     ack_checksum;
      logic                     packet_good;
      logic                     transfer_done;
      logic [3:0]               pad;
      logic                     last;
   } response_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // Receiver state as predicted from the accepted requests.
   logic              rx_expected_seq = 1'b0;
   int                rx_position     = 0;
   logic [31:0]       rx_seq_field    = '0;
   logic [31:0]       rx_len_field    = '0;
   logic [31:0]       rx_chk_field    = '0;
   logic [7:0]        rx_xor          = '0;
   logic [7:0]        rx_payload [abr_pkg::MAX_DATA];

   response_type pending_responses [$];

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_count    = 0;

   int bytes_sent        = 0;
   int datagrams_sent    = 0;
   int responses_checked = 0;
   int good_acks         = 0;
   int bad_acks          = 0;
   int mismatch_count    = 0;
   int error_count       = 0;

   alternating_bit_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   // Queue one expected response.
   function automatic void push_response(abr_pkg::result_kind_type kind, logic [7:0] data,
                                         logic seq, logic good, logic done);
      response_type r;
      r.kind          = kind;
      r.data_byte     = data;
      r.ack_seq       = seq;
      r.ack_checksum  = seq;
      r.packet_good   = good;
      r.transfer_done = done;
      r.pad           = 4'h0;
      r.last          = (kind == abr_pkg::KIND_ACK);
      pending_responses.push_back(r);
   endfunction

   // Fold one accepted datagram byte into the predicted state; on the end
   // mark, classify the datagram and queue its responses.
   function automatic void absorb_datagram_byte(logic [7:0] b, logic eod);
      int          sh;
      int          idx;
      logic [31:0] sum;
      logic        ok;
      logic        done;
      sh = (rx_position % 4) * 8;
      if (rx_position < abr_pkg::HDR_BYTES) begin
         if (rx_position < 4) begin
            rx_seq_field = rx_seq_field | (32'(b) << sh);
            rx_xor       = rx_xor ^ b;
         end else if (rx_position < 8) begin
            rx_len_field = rx_len_field | (32'(b) << sh);
            rx_xor       = rx_xor ^ b;
         end else begin
            rx_chk_field = rx_chk_field | (32'(b) << sh);
         end
      end else if (rx_position < abr_pkg::FRAME_BYTES) begin
         idx = rx_position - abr_pkg::HDR_BYTES;
         rx_payload[idx] = b;
         if (32'(idx) < rx_len_field)
            rx_xor = rx_xor ^ b;
      end
      if (rx_position < abr_pkg::FRAME_BYTES)
         rx_position++;
      if (!eod)
         return;

      // The checksum is the running XOR sign-extended to 32 bits.
      sum = {{24{rx_xor[7]}}, rx_xor};
      ok  = (rx_position >= abr_pkg::HDR_BYTES)
            && (rx_len_field <= 32'(abr_pkg::MAX_DATA));
      if (ok)
         ok = (32'(rx_position) >= 32'(abr_pkg::HDR_BYTES) + rx_len_field)
              && (rx_chk_field == sum)
              && (rx_seq_field == {31'b0, rx_expected_seq});
      if (ok) begin
         done = (rx_len_field == 0);
         for (int i = 0; 32'(i) < rx_len_field; i++)
            push_response(abr_pkg::KIND_DATA, rx_payload[i], 1'b0, 1'b1, 1'b0);
         push_response(abr_pkg::KIND_ACK, 8'h00, rx_expected_seq, 1'b1, done);
         rx_expected_seq = done ? 1'b0 : ~rx_expected_seq;
      end else begin
         push_response(abr_pkg::KIND_ACK, 8'h00, ~rx_expected_seq, 1'b0, 1'b0);
      end
      rx_position  = 0;
      rx_seq_field = '0;
      rx_len_field = '0;
      rx_chk_field = '0;
      rx_xor       = '0;
   endfunction

   // Offer one request, with random idle cycles first, and wait for it to be taken.
   task automatic send_request(input logic [7:0] b, input logic l);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      absorb_datagram_byte(b, l);
   endtask

   // Build and send one datagram. The checksum is made correct for the
   // header and the counted data, then flipped by chk_flip; fill < 0 gives
   // random data bytes. Only the first nbytes bytes are sent.
   task automatic send_datagram(input logic [31:0] seq, input logic [31:0] len,
                                input logic [31:0] chk_flip, input int nbytes,
                                input int fill);
      logic [7:0]  frame [$];
      logic [7:0]  xsum;
      logic [31:0] chk;
      frame = {};
      xsum  = 8'h00;
      for (int i = 0; i < 4; i++) frame.push_back(seq[8*i +: 8]);
      for (int i = 0; i < 4; i++) frame.push_back(len[8*i +: 8]);
      for (int i = 0; i < 4; i++) frame.push_back(8'h00);
      for (int i = abr_pkg::HDR_BYTES; i < nbytes; i++)
         frame.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      for (int i = 0; i < 8; i++) xsum ^= frame[i];
      for (int i = 0; i < abr_pkg::MAX_DATA && abr_pkg::HDR_BYTES + i < nbytes; i++)
         if (32'(i) < len) xsum ^= frame[abr_pkg::HDR_BYTES + i];
      chk = {{24{xsum[7]}}, xsum} ^ chk_flip;
      for (int i = 0; i < 4; i++) frame[8 + i] = chk[8*i +: 8];
      for (int i = 0; i < nbytes; i++)
         send_request(frame[i], i == nbytes - 1);
      datagrams_sent++;
   endtask

   // Send a well-formed datagram carrying the expected sequence.
   task automatic send_good(input int len, input int fill);
      send_datagram({31'b0, rx_expected_seq}, len, '0, abr_pkg::HDR_BYTES + len, fill);
   endtask

   // Stop offering requests until every expected response has arrived.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random datagram: mostly well formed, the rest broken in one way.
   task automatic send_random_datagram();
      int          pick;
      int          len;
      int          nbytes;
      logic [31:0] seq;
      logic [31:0] len_field;
      logic [31:0] flip;
      pick      = $urandom_range(0, 99);
      len       = ($urandom_range(0, 99) < 6) ? 0 : $urandom_range(1, abr_pkg::MAX_DATA);
      len_field = len;
      seq       = {31'b0, rx_expected_seq};
      flip      = '0;
      nbytes    = abr_pkg::HDR_BYTES + len;
      if ($urandom_range(0, 3) == 0)
         nbytes += $urandom_range(0, abr_pkg::MAX_DATA - len);
      if (pick < 65) begin
         // well formed
      end else if (pick < 72) begin
         seq = {31'b0, ~rx_expected_seq};
      end else if (pick < 76) begin
         seq = seq | (32'h1 << $urandom_range(1, 31));
      end else if (pick < 82) begin
         flip = 32'h1 << $urandom_range(0, 31);
      end else if (pick < 86) begin
         len_field = ($urandom_range(0, 1) == 0)
                     ? 32'($urandom_range(abr_pkg::MAX_DATA + 1, 255))
                     : ($urandom & 32'h7FFF_FFFF) | 32'h0000_0100;
         nbytes    = abr_pkg::HDR_BYTES + $urandom_range(0, abr_pkg::MAX_DATA);
      end else if (pick < 89) begin
         len_field = $urandom | 32'h8000_0000;
         nbytes    = abr_pkg::HDR_BYTES + $urandom_range(0, abr_pkg::MAX_DATA);
      end else if (pick < 94) begin
         nbytes = $urandom_range(1, abr_pkg::HDR_BYTES + len - 1);
      end else begin
         nbytes = $urandom_range(abr_pkg::FRAME_BYTES + 1, abr_pkg::FRAME_BYTES + 8);
      end
      send_datagram(seq, len_field, flip, nbytes, -1);
   endtask

   // Good datagrams at both ends of the data length and byte range.
   task automatic test_good_packets();
      send_good(abr_pkg::MAX_DATA, 8'hFF);
      send_good(1, 8'h00);
      send_good(abr_pkg::MAX_DATA - 1, -1);
      wait_for_drain();
   endtask

   // Wrong checksum, including the sign-extended upper bits.
   task automatic test_bad_checksum();
      send_datagram({31'b0, rx_expected_seq}, 4, 32'hFFFF_FF00,
                    abr_pkg::HDR_BYTES + 4, -1);
      send_datagram({31'b0, rx_expected_seq}, 2, 32'h0000_0001,
                    abr_pkg::HDR_BYTES + 2, -1);
      wait_for_drain();
   endtask

   // Sequence field differs from the expected bit, also in its upper bits.
   task automatic test_wrong_sequence();
      send_datagram({31'b0, ~rx_expected_seq}, 3, '0, abr_pkg::HDR_BYTES + 3, -1);
      send_datagram({31'b0, rx_expected_seq} | 32'h100, 1, '0, abr_pkg::HDR_BYTES + 1, -1);
      wait_for_drain();
   endtask

   // Length above the buffer size, both small and large, and negative as a signed value.
   task automatic test_invalid_length();
      send_datagram({31'b0, rx_expected_seq}, abr_pkg::MAX_DATA + 1, '0,
                    abr_pkg::FRAME_BYTES, -1);
      send_datagram({31'b0, rx_expected_seq}, 32'hFFFF_FFFF, '0, abr_pkg::HDR_BYTES, -1);
      send_datagram({31'b0, rx_expected_seq}, 32'h7FFF_FFFF, '0,
                    abr_pkg::HDR_BYTES + 2, -1);
      wait_for_drain();
   endtask

   // Datagrams that end inside the header or inside the counted data.
   task automatic test_short_datagrams();
      send_datagram({31'b0, rx_expected_seq}, 0, '0, 1, -1);
      send_datagram({31'b0, rx_expected_seq}, 0, '0, abr_pkg::HDR_BYTES - 1, -1);
      send_datagram({31'b0, rx_expected_seq}, 5, '0, abr_pkg::HDR_BYTES + 4, -1);
      wait_for_drain();
   endtask

   // Bytes past the buffer are dropped but their end mark still counts.
   task automatic test_oversize_datagram();
      send_datagram({31'b0, rx_expected_seq}, abr_pkg::MAX_DATA, '0,
                    abr_pkg::FRAME_BYTES + 8, -1);
      wait_for_drain();
   endtask

   // A zero-length packet ends the transfer from either sequence bit.
   task automatic test_end_of_transfer();
      send_good(2, -1);
      send_good(0, -1);
      send_good(0, -1);
      wait_for_drain();
   endtask

   // The receiver holds off while the sender keeps offering datagrams.
   task automatic test_receiver_hold_off();
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 6; i++) send_good($urandom_range(1, 2), -1);
      wait_for_drain();
   endtask

   // Random datagrams with the given idle rates until enough bytes have gone.
   task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_bytes);
      int target;
      send_idle_pct = s_pct;
      rcv_idle_pct  = r_pct;
      target        = bytes_sent + n_bytes;
      while (bytes_sent < target) send_random_datagram();
      wait_for_drain();
   endtask

   // Response channel: drive the ready and check every accepted response.
   always @(posedge clock) begin : response_check
      response_type got;
      response_type want;
      logic         bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind          = abr_pkg::result_kind_type'(rsp_tuser);
         got.data_byte     = rsp_tdata[7:0];
         got.ack_seq       = rsp_tdata[8];
         got.ack_checksum  = rsp_tdata[9];
         got.packet_good   = rsp_tdata[10];
         got.transfer_done = rsp_tdata[11];
         got.pad           = rsp_tdata[15:12];
         got.last          = rsp_tlast;
         responses_checked++;
         if (pending_responses.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: response with none expected: kind %0d data %02h tdata %04h",
                        $realtime, got.kind, got.data_byte, rsp_tdata);
         end else begin
            want = pending_responses.pop_front();
            bad  = (got.kind != want.kind) || (got.data_byte != want.data_byte)
                   || (got.ack_seq != want.ack_seq)
                   || (got.ack_checksum != want.ack_checksum)
                   || (got.packet_good != want.packet_good)
                   || (got.transfer_done != want.transfer_done)
                   || (got.pad != want.pad) || (got.last != want.last);
            if (want.kind == abr_pkg::KIND_ACK && want.packet_good) good_acks++;
            if (want.kind == abr_pkg::KIND_ACK && !want.packet_good) bad_acks++;
            if (bad) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"%0t: mismatch: expected kind %0d data %02h seq %0d chk %0d ",
                            "good %0d done %0d pad %0h last %0d, got kind %0d data %02h ",
                            "seq %0d chk %0d good %0d done %0d pad %0h last %0d"},
                           $realtime, want.kind, want.data_byte, want.ack_seq,
                           want.ack_checksum, want.packet_good, want.transfer_done,
                           want.pad, want.last, got.kind, got.data_byte, got.ack_seq,
                           got.ack_checksum, got.packet_good, got.transfer_done,
                           got.pad, got.last);
            end
         end
      end

      // Long hold-off when requested, random idling otherwise.
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_count  = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // Test sequence.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 27;
      rcv_idle_pct  = 76;
      test_good_packets();
      test_bad_checksum();
      test_wrong_sequence();
      test_invalid_length();
      test_short_datagrams();
      test_oversize_datagram();
      test_end_of_transfer();
      test_receiver_hold_off();

      test_random_traffic(27, 76, 35);
      test_random_traffic(76, 27, 35);
      test_random_traffic(0, 0, 35);

      error_count += pending_responses.size();
      $display("Sent %0d datagrams (%0d request bytes); checked %0d responses,",
               datagrams_sent, bytes_sent, responses_checked);
      $display("with %0d accepted and %0d rejected datagrams acknowledged.",
               good_acks, bad_acks);
      if (error_count == 0)
         $display("tb_alternating_bit_receiver: PASS");
      else
         $display("tb_alternating_bit_receiver: FAIL");
      $finish;
   end

   // Guard against a hang anywhere in the run.
   initial begin
      #2_000_000;
      $display("tb_alternating_bit_receiver: FAIL");
      $finish;
   end

endmodule

// File: files.f
rtl/core/abr_pkg.sv
rtl/core/abr_front.sv
rtl/core/abr_queue.sv
rtl/core/abr_back.sv
rtl/core/alternating_bit_receiver.sv
dv/tb_alternating_bit_receiver.sv
